/* sv/arr_pkg.sv */
// Shared constants, codes and tables of the adaptive Rice range decoder.
package arr_pkg;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_SYM     = 4'd1;
    localparam logic [3:0] PH_OLD_K   = 4'd2;
    localparam logic [3:0] PH_OLD_LO  = 4'd3;
    localparam logic [3:0] PH_OLD_HI  = 4'd4;
    localparam logic [3:0] PH_ESC_HI  = 4'd5;
    localparam logic [3:0] PH_ESC_LO  = 4'd6;
    localparam logic [3:0] PH_BASE    = 4'd7;
    localparam logic [3:0] PH_BASE_HI = 4'd8;
    localparam logic [3:0] PH_BASE_LO = 4'd9;

    localparam logic [1:0] CFG_MODEL = 2'd0;
    localparam logic [1:0] CFG_K     = 2'd1;
    localparam logic [1:0] CFG_KSUM  = 2'd2;

    localparam logic [31:0] TOP_LIMIT = 32'h0080_0000;
    localparam logic [31:0] SYM_LIMIT = 32'd65492;
    localparam logic [31:0] Q_LIMIT   = 32'd65535;
    localparam logic [31:0] ESC_BASE  = 32'd65472;
    localparam logic [4:0]  K_MAX     = 5'd27;
    localparam logic [5:0]  SYM_ESC   = 6'd63;
    localparam logic [3:0]  MAX_RES   = 4'd8;

    function automatic logic [15:0] cum_old(input logic [4:0] i);
        logic [15:0] v;
        unique case (i)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd14824;
            5'd2:  v = 16'd28224;
            5'd3:  v = 16'd39348;
            5'd4:  v = 16'd47855;
            5'd5:  v = 16'd53994;
            5'd6:  v = 16'd58171;
            5'd7:  v = 16'd60926;
            5'd8:  v = 16'd62682;
            5'd9:  v = 16'd63786;
            5'd10: v = 16'd64463;
            5'd11: v = 16'd64878;
            5'd12: v = 16'd65126;
            5'd13: v = 16'd65276;
            5'd14: v = 16'd65365;
            5'd15: v = 16'd65419;
            5'd16: v = 16'd65450;
            5'd17: v = 16'd65469;
            5'd18: v = 16'd65480;
            5'd19: v = 16'd65487;
            5'd20: v = 16'd65491;
            default: v = 16'd65493;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] cum_new(input logic [4:0] i);
        logic [15:0] v;
        unique case (i)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd19578;
            5'd2:  v = 16'd36160;
            5'd3:  v = 16'd48417;
            5'd4:  v = 16'd56323;
            5'd5:  v = 16'd60899;
            5'd6:  v = 16'd63265;
            5'd7:  v = 16'd64435;
            5'd8:  v = 16'd64971;
            5'd9:  v = 16'd65232;
            5'd10: v = 16'd65351;
            5'd11: v = 16'd65416;
            5'd12: v = 16'd65447;
            5'd13: v = 16'd65466;
            5'd14: v = 16'd65476;
            5'd15: v = 16'd65482;
            5'd16: v = 16'd65485;
            5'd17: v = 16'd65488;
            5'd18: v = 16'd65490;
            5'd19: v = 16'd65491;
            5'd20: v = 16'd65492;
            default: v = 16'd65493;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] cum_sel(input logic model, input logic [4:0] i);
        return model ? cum_new(i) : cum_old(i);
    endfunction

    // Count table boundaries at or below q; the table is monotonic.
    function automatic logic [4:0] sym_search(input logic model, input logic [15:0] q);
        logic [4:0] s;
        s = 5'd0;
        for (int i = 1; i <= 20; i++) begin
            if (cum_sel(model, 5'(i)) <= q) s = s + 5'd1;
        end
        return s;
    endfunction

    function automatic logic [31:0] kbound(input logic [4:0] k);
        return (k == 5'd0) ? 32'd0 : (32'd1 << (k + 5'd4));
    endfunction

endpackage

/* sv/arr_div.sv */
// Iterative 32-bit unsigned restoring divider, one quotient bit per cycle.
module arr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_den;
    logic [32:0] trial;
    logic        fits;

    assign trial = {r_rem, r_quo[31]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* sv/adaptive_rice_range_decoder.sv */
// Top level of the adaptive Rice range decoder: sequencer, coder state and result queue.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one compressed byte per
//   transfer. i_req_type = 0 starts a frame with that byte, 1 feeds a data byte.
//   Output channel (o_out_valid / i_out_ready) returns signed residuals; o_last
//   marks the final result caused by one byte, o_error flags an invalid symbol
//   after which data bytes are dropped until the next frame start.
//   Configuration channel (i_cfg_valid / o_cfg_ready) is always ready; index
//   0 selects the model, 1 the initial k, 2 the initial ksum.
// Sequencing:
//   A frame start gives no result. Each decoding step takes one or two
//   divider passes plus sequencer states; a byte runs steps for up to 8
//   results. The input is not ready while a byte is in work.
//   Results wait in one held slot and one output register, so a stalled
//   receiver only holds the sequencer when both are full.
// Reset:
//   Clears the sequencer and output register, restores configuration
//   defaults and leaves the decoder awaiting a frame start.
module adaptive_rice_range_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_sample,
    output logic        o_error,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import arr_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_LOOP  = 12'b0000_0000_0010,
        S_OP    = 12'b0000_0000_0100,
        S_NORM  = 12'b0000_0000_1000,
        S_DIVR  = 12'b0000_0001_0000,
        S_DIVQ  = 12'b0000_0010_0000,
        S_MUL   = 12'b0000_0100_0000,
        S_TBL   = 12'b0000_1000_0000,
        S_POST  = 12'b0001_0000_0000,
        S_FIN1  = 12'b0010_0000_0000,
        S_FIN2  = 12'b0100_0000_0000,
        S_DELIV = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_low, n_low, r_range, n_range, r_buf, n_buf;
    logic [4:0]  r_k, n_k;
    logic [31:0] r_ksum, n_ksum, r_ovf, n_ovf, r_part, n_part;
    logic        r_cur_model, n_cur_model;
    logic [31:0] r_q, n_q;
    logic [4:0]  r_sym, n_sym;
    logic [31:0] r_h, n_h;
    logic [4:0]  r_b, n_b;
    logic [31:0] r_x, n_x, r_s, n_s;
    logic        r_e, n_e;
    logic        r_pend_v, n_pend_v, r_pend_e, n_pend_e;
    logic [31:0] r_pend_s, n_pend_s;
    logic [3:0]  r_n, n_n;
    logic        r_out_v, n_out_v, r_out_e, n_out_e, r_out_l, n_out_l;
    logic [31:0] r_out_s, n_out_s;
    logic        r_model_sel;
    logic [4:0]  r_init_k;
    logic [31:0] r_init_ksum;

    logic        div_start, div_done;
    logic [31:0] div_a, div_b, div_q;
    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] pivot, rsh, sym_q, x_half;
    logic [4:0]  tk, sym_hit;
    logic [5:0]  sym6;
    logic        in_acc, out_free, esc_q;

    arr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_v || i_out_ready;
    assign o_out_valid = r_out_v;
    assign o_sample    = r_out_s;
    assign o_error     = r_out_e;
    assign o_last      = r_out_l;

    assign pivot   = (r_ksum[31:5] == 27'd0) ? 32'd1 : {5'd0, r_ksum[31:5]};
    assign tk      = r_part[4:0];
    assign esc_q   = r_q > SYM_LIMIT;
    assign sym_hit = sym_search(r_cur_model, r_q[15:0]);
    assign sym_q   = r_q - ESC_BASE;
    assign sym6    = esc_q ? sym_q[5:0] : {1'b0, r_sym};
    assign mul_p   = mul_a * mul_b;
    assign x_half  = r_x >> 1;

    // Range shift of the current step before its low / range division.
    always_comb begin
        unique case (r_phase)
            PH_OLD_K:  rsh = r_range >> 5;
            PH_OLD_LO: rsh = r_range >> ((tk <= 5'd16) ? tk : 5'd16);
            PH_OLD_HI: rsh = r_range >> (r_ovf[4:0] - 5'd16);
            default:   rsh = r_range >> 16;
        endcase
    end

    // Operand select of the shared multiplier.
    always_comb begin
        mul_a = r_range;
        mul_b = r_q;
        if (r_state == S_MUL) begin
            if (r_phase == PH_SYM && !esc_q)
                mul_b = {16'd0, cum_sel(r_cur_model, sym_hit)};
        end else if (r_state == S_TBL) begin
            mul_b = {16'd0, 16'(cum_sel(r_cur_model, r_sym + 5'd1)
                                - cum_sel(r_cur_model, r_sym))};
        end else if (r_state == S_POST) begin
            mul_a = r_ovf;
            mul_b = pivot;
        end
    end

    always_comb begin
        n_state = r_state;      n_phase = r_phase;   n_low = r_low;
        n_range = r_range;      n_buf = r_buf;       n_k = r_k;
        n_ksum = r_ksum;        n_ovf = r_ovf;       n_part = r_part;
        n_cur_model = r_cur_model;  n_q = r_q;       n_sym = r_sym;
        n_h = r_h;              n_b = r_b;           n_x = r_x;
        n_s = r_s;              n_e = r_e;           n_pend_v = r_pend_v;
        n_pend_s = r_pend_s;    n_pend_e = r_pend_e; n_n = r_n;
        n_out_v = r_out_v;      n_out_s = r_out_s;   n_out_e = r_out_e;
        n_out_l = r_out_l;
        div_start = 1'b0;       div_a = r_low;       div_b = rsh;

        // Drop the output register once the receiver takes it.
        if (r_out_v && i_out_ready) n_out_v = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_req_type) begin
                        n_buf   = {24'd0, i_data_byte};
                        n_low   = {25'd0, i_data_byte[7:1]};
                        n_range = 32'd128;
                        n_k     = (r_init_k > K_MAX) ? K_MAX : r_init_k;
                        n_ksum  = r_init_ksum;
                        n_ovf   = 32'd0;
                        n_part  = 32'd0;
                        n_phase = PH_SYM;
                    end else if (r_phase == PH_IDLE || r_phase > PH_BASE_LO) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_buf   = {r_buf[23:0], i_data_byte};
                        n_low   = {r_low[23:0], r_buf[0], i_data_byte[7:1]};
                        n_range = r_range << 8;
                        n_n     = 4'd0;
                        n_state = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                if (r_phase != PH_IDLE && r_range > TOP_LIMIT && r_n < MAX_RES) begin
                    n_state = S_OP;
                end else if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    // Flush the held result as the last one of this byte.
                    n_out_v  = 1'b1;
                    n_out_s  = r_pend_s;
                    n_out_e  = r_pend_e;
                    n_out_l  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_OP: begin
                priority if (r_phase == PH_BASE) begin
                    div_start = 1'b1;
                    div_a     = r_range;
                    div_b     = pivot;
                    n_state   = S_DIVR;
                end else if (r_phase == PH_BASE_HI || r_phase == PH_BASE_LO) begin
                    n_h     = pivot;
                    n_b     = 5'd0;
                    n_state = S_NORM;
                end else if (r_phase >= PH_SYM && r_phase <= PH_ESC_LO) begin
                    if (r_phase == PH_SYM) n_cur_model = r_model_sel;
                    n_range   = rsh;
                    div_start = 1'b1;
                    n_state   = S_DIVQ;
                end else begin
                    n_phase = PH_IDLE;
                    n_state = S_LOOP;
                end
            end
            S_NORM: begin
                if (r_h[31:16] != 16'd0) begin
                    n_h = r_h >> 1;
                    n_b = r_b + 5'd1;
                end else if (r_phase == PH_BASE_HI) begin
                    div_start = 1'b1;
                    div_a     = r_range;
                    div_b     = r_h + 32'd1;
                    n_state   = S_DIVR;
                end else begin
                    n_range   = r_range >> r_b;
                    div_start = 1'b1;
                    div_b     = r_range >> r_b;
                    n_state   = S_DIVQ;
                end
            end
            S_DIVR: begin
                if (div_done) begin
                    n_range   = div_q;
                    div_start = 1'b1;
                    div_b     = div_q;
                    n_state   = S_DIVQ;
                end
            end
            S_DIVQ: begin
                if (div_done) begin
                    n_q     = div_q;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_low = r_low - mul_p;
                if (r_phase == PH_SYM && !esc_q) begin
                    n_sym   = sym_hit;
                    n_state = S_TBL;
                end else begin
                    n_state = S_POST;
                end
            end
            S_TBL: begin
                n_range = mul_p;
                n_state = S_POST;
            end
            S_POST: begin
                n_state = S_LOOP;
                unique case (r_phase)
                    PH_SYM: begin
                        if (r_q > Q_LIMIT) begin
                            n_phase = PH_IDLE;
                            n_s     = 32'd0;
                            n_e     = 1'b1;
                            n_state = S_DELIV;
                        end else if (!r_cur_model) begin
                            if (sym6 == SYM_ESC) begin
                                n_ovf   = 32'd0;
                                n_phase = PH_OLD_K;
                            end else begin
                                n_ovf   = {26'd0, sym6};
                                n_part  = {27'd0, (r_k != 5'd0) ? r_k - 5'd1 : 5'd0};
                                n_phase = PH_OLD_LO;
                            end
                        end else if (sym6 == SYM_ESC) begin
                            n_phase = PH_ESC_HI;
                        end else begin
                            n_ovf   = {26'd0, sym6};
                            n_phase = (pivot[31:16] == 16'd0) ? PH_BASE : PH_BASE_HI;
                        end
                    end
                    PH_OLD_K: begin
                        n_part  = {27'd0, r_q[4:0]};
                        n_phase = PH_OLD_LO;
                    end
                    PH_OLD_LO: begin
                        n_part = r_q + (r_ovf << tk);
                        n_ovf  = {27'd0, tk};
                        if (tk > 5'd16) begin
                            n_phase = PH_OLD_HI;
                        end else begin
                            n_x     = r_q + (r_ovf << tk);
                            n_state = S_FIN1;
                        end
                    end
                    PH_OLD_HI: begin
                        n_x     = r_part + (r_q << 16);
                        n_state = S_FIN1;
                    end
                    PH_ESC_HI: begin
                        n_ovf   = r_q << 16;
                        n_phase = PH_ESC_LO;
                    end
                    PH_ESC_LO: begin
                        n_ovf   = r_ovf | r_q;
                        n_phase = (pivot[31:16] == 16'd0) ? PH_BASE : PH_BASE_HI;
                    end
                    PH_BASE: begin
                        n_x     = r_q + mul_p;
                        n_state = S_FIN1;
                    end
                    PH_BASE_HI: begin
                        n_part  = r_q;
                        n_phase = PH_BASE_LO;
                    end
                    PH_BASE_LO: begin
                        n_x     = (r_part << r_b) + r_q + mul_p;
                        n_state = S_FIN1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            S_FIN1: begin
                n_ksum  = r_ksum + ((r_x + 32'd1) >> 1) - ((r_ksum + 32'd16) >> 5);
                n_s     = r_x[0] ? x_half + 32'd1 : 32'd0 - x_half;
                n_e     = 1'b0;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                priority if (r_ksum < kbound(r_k)) begin
                    if (r_k != 5'd0) n_k = r_k - 5'd1;
                end else if (r_k < K_MAX && r_ksum >= kbound(r_k + 5'd1)) begin
                    n_k = r_k + 5'd1;
                end else begin
                    n_k = r_k;
                end
                n_phase = PH_SYM;
                n_state = S_DELIV;
            end
            S_DELIV: begin
                // Hold the new result until it is known whether it is the last.
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out_s = r_pend_s;
                        n_out_e = r_pend_e;
                        n_out_l = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend_s = r_s;
                    n_pend_e = r_e;
                    n_n      = r_n + 4'd1;
                    n_state  = S_LOOP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_n         <= 4'd0;
            r_model_sel <= 1'b1;
            r_init_k    <= 5'd10;
            r_init_ksum <= 32'd16384;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_n      <= n_n;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODEL: r_model_sel <= i_cfg_data[0];
                    CFG_K:     r_init_k    <= i_cfg_data[4:0];
                    CFG_KSUM:  r_init_ksum <= i_cfg_data;
                    default:   r_model_sel <= r_model_sel;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low       <= n_low;
        r_range     <= n_range;
        r_buf       <= n_buf;
        r_k         <= n_k;
        r_ksum      <= n_ksum;
        r_ovf       <= n_ovf;
        r_part      <= n_part;
        r_cur_model <= n_cur_model;
        r_q         <= n_q;
        r_sym       <= n_sym;
        r_h         <= n_h;
        r_b         <= n_b;
        r_x         <= n_x;
        r_s         <= n_s;
        r_e         <= n_e;
        r_pend_s    <= n_pend_s;
        r_pend_e    <= n_pend_e;
        r_out_s     <= n_out_s;
        r_out_e     <= n_out_e;
        r_out_l     <= n_out_l;
    end
endmodule
